>>> rtl/md5_pkg.sv
// Shared types, constants and round functions for the MD5 digest block.
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    // Queue entry from the front end to the back end
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
        logic       valid;
    } t_front;

    function automatic logic [31:0] sine_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] r;
        case ({i[5:4], i[1:0]})
            4'd0: r = 5'd7;  4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
            4'd4: r = 5'd5;  4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
            4'd8: r = 5'd4;  4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
            4'd12: r = 5'd6; 4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
        endcase
        return r;
    endfunction

    // Message word index for step i
    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] j;
        logic [3:0] w;
        j = i[3:0];
        case (i[5:4])
            2'd0: w = j;
            2'd1: w = 4'(5 * j + 1);
            2'd2: w = 4'(3 * j + 5);
            default: w = 4'(7 * j);
        endcase
        return w;
    endfunction

    function automatic logic [31:0] round_fn(input logic [1:0] rnd, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (rnd)
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (b & d) | (c & ~d);
            2'd2: f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

>>> rtl/md5_front.sv
// Input stage: takes items, drops empty non-last ones, feeds a two-entry queue.
module md5_front
    import md5_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_has_byte,
    input  logic       i_is_last,
    output t_item      o_item,
    output logic       o_item_valid,
    input  logic       i_item_ready
);

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready      = (r_cnt != 2'd2);
    assign w_push       = i_valid && o_ready && (i_has_byte || i_is_last);
    assign w_pop        = o_item_valid && i_item_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{data_byte: i_data_byte, has_byte: i_has_byte, is_last: i_is_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= 2'(r_cnt + {1'b0, w_push} - {1'b0, w_pop});
        end
    end

endmodule

>>> rtl/md5_core.sv
// Back end: block packing, padding, 64-step compression and digest output.
module md5_core
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic        i_item_valid,
    output logic        o_item_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_number,
    output logic        o_final_word
);

    t_state      r_state, n_state;
    logic [31:0] r_blk [16];
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [63:0] r_bits;
    logic [5:0]  r_pos;
    logic [5:0]  r_step;
    logic [2:0]  r_lenb;
    logic        r_last;
    logic        r_len_done;
    logic        r_ovalid;
    logic [1:0]  r_onum;
    logic [31:0] r_oword;

    logic        w_take;
    logic        w_wr;
    logic [7:0]  w_byte;
    logic [31:0] w_t, w_rot;
    logic [4:0]  w_sh;
    logic        w_odone;

    assign o_item_ready = (r_state == S_IDLE);
    assign w_take       = i_item_valid && o_item_ready;
    assign w_odone      = r_ovalid && i_ready;

    // Byte written into the block this cycle
    always_comb begin
        w_wr   = 1'b0;
        w_byte = 8'h00;
        case (r_state)
            S_IDLE: begin
                w_wr   = w_take && i_item.has_byte;
                w_byte = i_item.data_byte;
            end
            S_PAD: begin
                w_wr   = 1'b1;
                w_byte = 8'h00;
            end
            S_LEN: begin
                w_wr   = 1'b1;
                w_byte = 8'(r_bits >> {r_lenb, 3'b000});
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (i_item.has_byte && r_pos == 6'd63) n_state = S_LOAD;
                    else if (i_item.is_last)               n_state = S_PAD;
                end
            end
            // First pad cycle writes 0x80 (see r_blk write), then zeros up to byte 56
            S_PAD: begin
                if (r_pos == 6'd63)              n_state = S_LOAD;
                else if (r_pos == LEN_POS - 6'd1) n_state = S_LEN;
            end
            S_LEN:   if (r_lenb == 3'd7) n_state = S_LOAD;
            S_LOAD:  n_state = S_ROUND;
            S_ROUND: if (r_step == 6'd63) n_state = S_ADD;
            S_ADD:   n_state = r_last ? (r_len_done ? S_OUT : S_PAD) : S_IDLE;
            S_OUT:   if (w_odone && r_onum == 2'd3) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_sh  = rot_amount(r_step);
        w_t   = r_a + round_fn(r_step[5:4], r_b, r_c, r_d) + r_blk[msg_index(r_step)]
                + sine_k(r_step);
        w_rot = (w_t << w_sh) | (w_t >> (6'd32 - {1'b0, w_sh}));
    end

    // r_pad0 marks whether the 0x80 byte is still owed
    logic r_pad0;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            case (r_pos[1:0])
                2'd0: r_blk[r_pos[5:2]] <= {24'h0, (r_state == S_PAD && r_pad0)
                                             ? PAD_BYTE : w_byte};
                2'd1: r_blk[r_pos[5:2]][15:8]  <= (r_state == S_PAD && r_pad0)
                                                  ? PAD_BYTE : w_byte;
                2'd2: r_blk[r_pos[5:2]][23:16] <= (r_state == S_PAD && r_pad0)
                                                  ? PAD_BYTE : w_byte;
                default: r_blk[r_pos[5:2]][31:24] <= (r_state == S_PAD && r_pad0)
                                                    ? PAD_BYTE : w_byte;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
        end else if (r_state == S_ROUND) begin
            r_a <= r_d; r_b <= r_b + w_rot; r_c <= r_b; r_d <= r_c;
        end
        if (r_state == S_OUT && (!r_ovalid || w_odone)) begin
            r_oword <= bswap(r_h[r_ovalid ? 2'(r_onum + 2'd1) : 2'd0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_h        <= '{IV_A, IV_B, IV_C, IV_D};
            r_bits     <= '0;
            r_pos      <= '0;
            r_step     <= '0;
            r_lenb     <= '0;
            r_last     <= 1'b0;
            r_len_done <= 1'b0;
            r_pad0     <= 1'b0;
            r_ovalid   <= 1'b0;
            r_onum     <= '0;
        end else begin
            r_state <= n_state;
            if (w_wr) r_pos <= r_pos + 6'd1;
            if (r_state == S_PAD && w_wr) r_pad0 <= 1'b0;
            if (w_take) begin
                r_last     <= i_item.is_last;
                r_len_done <= 1'b0;
                r_pad0     <= 1'b1;
                if (i_item.has_byte) r_bits <= r_bits + 64'd8;
            end
            if (r_state == S_LEN) r_lenb <= r_lenb + 3'd1;
            // Length bytes in place: the next compression is the final one
            if (r_state == S_LEN && r_lenb == 3'd7) r_len_done <= 1'b1;
            if (r_state == S_ROUND) r_step <= r_step + 6'd1;
            if (r_state == S_ADD) begin
                r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
            end
            if (r_state == S_OUT) begin
                if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                    r_onum   <= 2'd0;
                end else if (w_odone) begin
                    r_onum <= r_onum + 2'd1;
                    if (r_onum == 2'd3) begin
                        r_ovalid <= 1'b0;
                        r_h      <= '{IV_A, IV_B, IV_C, IV_D};
                        r_bits   <= '0;
                        r_pos    <= '0;
                        r_last   <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_digest_word = r_oword;
    assign o_word_number = r_onum;
    assign o_final_word  = (r_onum == 2'd3);

endmodule

>>> rtl/md5_digest.sv
// MD5 digest: byte stream in, four digest words out; 64-step round loop, one step a cycle.
// Throughput: one byte per cycle while filling a block; each 64th byte then holds off further
//   bytes during the load, 64 steps and chain add in the single round unit.
// Last item: padding writes one byte a cycle up to 72 bytes, one or two compressions,
//   then four digest transfers, one per cycle when not stalled.
// Reset (i_rst_n low, synchronous) restores the MD5 initial chain and empties the queue.
module md5_digest
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_number,
    output logic        o_final_word
);

    t_item w_item;
    logic  w_item_valid;
    logic  w_item_ready;

    md5_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_data_byte, .i_has_byte, .i_is_last,
        .o_item(w_item), .o_item_valid(w_item_valid), .i_item_ready(w_item_ready)
    );

    md5_core u_core (
        .i_clk, .i_rst_n,
        .i_item(w_item), .i_item_valid(w_item_valid), .o_item_ready(w_item_ready),
        .o_valid, .i_ready, .o_digest_word, .o_word_number, .o_final_word
    );

endmodule

>>> dv/md5_digest_checker.sv
// Checker for the MD5 digest block: predicts digest words from accepted bytes and compares.
`timescale 1ns / 100ps
module md5_digest_checker
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_digest_word,
    input  logic [1:0]  i_word_number,
    input  logic        i_final_word,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [31:0] word;
        logic [1:0]  number;
        logic        final_flag;
    } t_digest_word;

    localparam logic [4:0] SHIFTS [16] = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
                                           5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    localparam logic [31:0] SINES [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
        32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
        32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
        32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
        32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
        32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

    logic [31:0]  chain [4];
    logic [31:0]  blk [16];
    logic [63:0]  msg_bits;
    logic [6:0]   fill;
    t_digest_word digest_q [$];
    int           fails;

    assign o_fail_count = fails;
    assign o_pending    = digest_q.size();

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
        return (v << n) | (v >> (6'd32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] a, b, c, d, f, t;
        int rnd, j, w;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int i = 0; i < 64; i++) begin
            rnd = i / 16;
            j = i % 16;
            case (rnd)
                0: begin f = (b & c) | (~b & d); w = j; end
                1: begin f = (b & d) | (c & ~d); w = (1 + 5 * j) % 16; end
                2: begin f = b ^ c ^ d; w = (5 + 3 * j) % 16; end
                default: begin f = c ^ (b | ~d); w = (7 * j) % 16; end
            endcase
            t = a + f + blk[w] + SINES[i];
            t = b + rotl(t, SHIFTS[rnd * 4 + (j % 4)]);
            a = d; d = c; c = b; b = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endtask

    task automatic absorb_byte(input logic [7:0] v);
        blk[fill[5:2]][fill[1:0] * 8 +: 8] = v;
        fill++;
        if (fill == 7'd64) begin
            compress_block();
            fill = '0;
        end
    endtask

    task automatic restart_digest();
        chain[0] = IV_A; chain[1] = IV_B; chain[2] = IV_C; chain[3] = IV_D;
        msg_bits = '0;
        fill = '0;
    endtask

    task automatic take_item(input logic [7:0] v, input logic has, input logic last);
        logic [63:0] len;
        t_digest_word e;
        if (has) begin
            absorb_byte(v);
            msg_bits += 64'd8;
        end
        if (last) begin
            len = msg_bits;
            absorb_byte(PAD_BYTE);
            while (fill != 7'(LEN_POS))
                absorb_byte(8'h00);
            for (int k = 0; k < 8; k++)
                absorb_byte(len[8 * k +: 8]);
            for (int k = 0; k < 4; k++) begin
                e.word = {chain[k][7:0], chain[k][15:8], chain[k][23:16], chain[k][31:24]};
                e.number = 2'(k);
                e.final_flag = (k == 3);
                digest_q.push_back(e);
            end
            restart_digest();
        end
    endtask

    initial begin
        fails = 0;
        restart_digest();
    end

    always @(posedge i_clk) begin
        t_digest_word e;
        if (!i_rst_n) begin
            restart_digest();
            digest_q.delete();
        end else begin
            if (i_valid && i_ready_in)
                take_item(i_data_byte, i_has_byte, i_is_last);
            if (i_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected digest transfer: word %h num %0d final %b",
                                 i_digest_word, i_word_number, i_final_word);
                end else begin
                    e = digest_q.pop_front();
                    if (e.word !== i_digest_word || e.number !== i_word_number
                        || e.final_flag !== i_final_word) begin
                        fails++;
                        if (fails <= 10)
                            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     e.word, e.number, e.final_flag,
                                     i_digest_word, i_word_number, i_final_word);
                    end
                end
            end
        end
    end

endmodule

>>> dv/tb_md5_digest.sv
// Testbench top for the MD5 digest block: byte-stream stimulus, output stalls and verdict.
`timescale 1ns / 100ps
module tb_md5_digest;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        has_byte = 1'b0;
    logic        is_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [1:0]  word_number;
    logic        final_word;
    int          fail_count;
    int          pending;
    int          idle_pct = 35;
    int          quiet_cycles = 0;

    always #1 clk = ~clk;

    md5_digest dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_data_byte(data_byte), .i_has_byte(has_byte), .i_is_last(is_last),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_digest_word(digest_word), .o_word_number(word_number), .o_final_word(final_word)
    );

    md5_digest_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_ready_in(in_ready),
        .i_data_byte(data_byte), .i_has_byte(has_byte), .i_is_last(is_last),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_digest_word(digest_word), .i_word_number(word_number), .i_final_word(final_word),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge clk) begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // One item; valid stays high back to back when no idle gap is drawn.
    task automatic send_item(input logic [7:0] v, input logic has, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= v;
        has_byte <= has;
        is_last <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_message(input int n_bytes, input int hole_pct);
        for (int k = 0; k < n_bytes; k++) begin
            if ($urandom_range(99) < hole_pct)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, 1'b0);
        end
        if ($urandom_range(1))
            send_item(8'($urandom), 1'b1, 1'b1);
        else
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial begin
        int sent;
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, lone extreme bytes, no-byte filler, padding boundaries
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'ha5, 1'b1, 1'b0);
        send_item(8'h33, 1'b0, 1'b1);
        wait_drained();
        send_message(55, 0);
        // long stretch with no stalls on either side
        idle_pct = 0;
        send_message(56, 0);
        idle_pct = 35;
        send_message(64, 0);
        wait_drained();

        // random: short messages with occasional no-byte filler
        sent = 0;
        while (sent < 36) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(12);
            send_message(n, 10);
            sent += n + 1;
            if ($urandom_range(7) == 0)
                wait_drained();
        end
        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
